// ===== design/tdl_pkg.sv =====
// ----------------------------------------------------------------------------
// tdl_pkg: shared types and constants
// Controller states, row status codes and the result records that the
// serial divider and the magnitude unit hand to the top level.
// ----------------------------------------------------------------------------
package tdl_pkg;

  localparam int QUOT_BITS = 31;

  localparam logic [31:0] SAT_POS      = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG      = 32'h8000_0000;
  localparam logic [15:0] FAIL_ROW_MAX = 16'hFFFF;

  localparam logic [1:0] STATUS_FACTORED   = 2'd0;
  localparam logic [1:0] STATUS_FIRST_FAIL = 2'd1;
  localparam logic [1:0] STATUS_PASSED     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIVOT,
    ST_MAG,
    ST_DIV,
    ST_DONE
  } tdl_state_t;

  typedef struct packed {
    logic                 done;
    logic                 ovf;
    logic [QUOT_BITS-1:0] quot;
  } tdl_div_res_t;

  typedef struct packed {
    logic        done;
    logic [63:0] sum;
  } tdl_mag_res_t;

endpackage

// ===== design/tdl_div.sv =====
// ----------------------------------------------------------------------------
// tdl_div: bit-serial restoring divider
// Divides a 64-bit unsigned dividend by a positive 31-bit divisor, one
// quotient bit per cycle, and flags a quotient that does not fit 31 bits.
// ----------------------------------------------------------------------------
module tdl_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [63:0]          dividend,
  input  logic [30:0]          divisor,
  output tdl_pkg::tdl_div_res_t res
);
  import tdl_pkg::*;

  logic                 busy;
  logic                 done;
  logic [4:0]           cnt;
  logic                 ovf;
  logic [QUOT_BITS-1:0] rem;
  logic [QUOT_BITS-1:0] sh;
  logic [31:0]          trial;
  logic [31:0]          diff;
  logic                 fit;

  assign trial = {rem, sh[QUOT_BITS-1]};
  assign fit   = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'(QUOT_BITS);
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The remainder never reaches the divisor, so the upper dividend bits are
  // zero whenever the quotient fits.
  always_ff @(posedge clk) begin
    if (start) begin
      ovf <= dividend[63:31] >= {2'b00, divisor};
      rem <= dividend[61:31];
      sh  <= dividend[30:0];
    end else if (busy) begin
      rem <= fit ? diff[QUOT_BITS-1:0] : trial[QUOT_BITS-1:0];
      sh  <= {sh[QUOT_BITS-2:0], fit};
    end
  end

  assign res = '{done: done, ovf: ovf, quot: sh};

endmodule

// ===== design/tdl_mag.sv =====
// ----------------------------------------------------------------------------
// tdl_mag: squared magnitude unit
// Forms a*a + b*b with one shared 32 by 32 multiplier, squaring a and then b.
// ----------------------------------------------------------------------------
module tdl_mag (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [31:0]          a,
  input  logic [31:0]          b,
  output tdl_pkg::tdl_mag_res_t res
);
  import tdl_pkg::*;

  logic [2:0]  stage;
  logic [31:0] operand;
  logic [63:0] prod;
  logic [63:0] acc;

  assign operand = stage[0] ? b : a;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage <= {stage[1:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start || stage[0]) begin
      prod <= operand * operand;
    end
    if (stage[0]) begin
      acc <= prod;
    end else if (stage[1]) begin
      acc <= acc + prod;
    end
  end

  assign res = '{done: stage[2], sum: acc};

endmodule

// ===== design/tridiagonal_ldlh_factor.sv =====
// ----------------------------------------------------------------------------
// Rows are processed one at a time: a new row is accepted only after the result
// of the last one has entered the output register. Factored rows that are not
// the last run the 31-step serial divide of the correction; others skip it.
// Reset: synchronous, active high; clears the controller state, correction,
// failure state, first failing row, row counter and output valid flag.
// ----------------------------------------------------------------------------
// tridiagonal_ldlh_factor: streaming LDL^H factorization
// Takes one row of a Hermitian tridiagonal matrix per request and returns the
// pivot, the multiplier and the failure status for that row.
// ----------------------------------------------------------------------------
module tridiagonal_ldlh_factor #(
  parameter int ROW_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // diag_in [31:0], off_real [63:32], off_imag [95:64]
  input  logic [95:0]  s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pivot_out [31:0], mult_real [63:32], mult_imag [95:64], fail_row [111:96]
  output logic [111:0] m_axis_tdata,
  // row_status [1:0]
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  import tdl_pkg::*;

  localparam int CNT_W = (ROW_BITS > 16) ? ROW_BITS + 1 : 17;

  tdl_state_t state, state_next;

  logic [31:0]         diag;
  logic [31:0]         off_re;
  logic [31:0]         off_im;
  logic                last;
  logic [31:0]         abs_re;
  logic [31:0]         abs_im;
  logic [30:0]         pivot;
  logic [30:0]         corr;
  logic                failed;
  logic [ROW_BITS-1:0] row_cnt;
  logic [15:0]         fail_row;

  logic [31:0] res_pivot;
  logic [31:0] res_mr;
  logic [31:0] res_mi;
  logic [1:0]  res_status;

  logic [32:0]      diff;
  logic [31:0]      piv_sat;
  logic             piv_bad;
  logic [CNT_W-1:0] row_ext;
  logic [15:0]      row_1based;
  logic             out_free;

  logic         mag_start;
  logic         div_start;
  tdl_mag_res_t mag_res;
  tdl_div_res_t div_re;
  tdl_div_res_t div_im;
  tdl_div_res_t div_mag;

  function automatic logic [31:0] sat_quot(input logic neg, input logic ovf,
                                           input logic [30:0] q);
    logic [31:0] mag;
    mag = {1'b0, q};
    if (ovf) begin
      sat_quot = neg ? SAT_NEG : SAT_POS;
    end else begin
      sat_quot = neg ? (32'd0 - mag) : mag;
    end
  endfunction

  assign diff    = {diag[31], diag} - {2'b00, corr};
  assign piv_sat = (diff[32] != diff[31]) ? SAT_NEG : diff[31:0];
  assign piv_bad = piv_sat[31] || (piv_sat == 32'd0);
  assign row_ext = CNT_W'(row_cnt) + CNT_W'(1);
  assign row_1based = (row_ext > CNT_W'(FAIL_ROW_MAX)) ? FAIL_ROW_MAX : row_ext[15:0];
  assign out_free = !m_axis_tvalid || m_axis_tready;

  tdl_mag u_mag (
    .clk   (clk),
    .rst   (rst),
    .start (mag_start),
    .a     (abs_re),
    .b     (abs_im),
    .res   (mag_res)
  );

  tdl_div u_div_re (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({16'd0, abs_re, 16'd0}),
    .divisor  (pivot),
    .res      (div_re)
  );

  tdl_div u_div_im (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({16'd0, abs_im, 16'd0}),
    .divisor  (pivot),
    .res      (div_im)
  );

  tdl_div u_div_mag (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag_res.sum),
    .divisor  (pivot),
    .res      (div_mag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    mag_start     = 1'b0;
    div_start     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = ST_PIVOT;
        end
      end
      ST_PIVOT: begin
        if (failed || piv_bad || last) begin
          state_next = ST_DONE;
        end else begin
          mag_start  = 1'b1;
          state_next = ST_MAG;
        end
      end
      ST_MAG: begin
        if (mag_res.done) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_mag.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_axis_tvalid) begin
      diag   <= s_axis_tdata[31:0];
      off_re <= s_axis_tdata[63:32];
      off_im <= s_axis_tdata[95:64];
      last   <= s_axis_tlast;
      abs_re <= s_axis_tdata[63] ? 32'd0 - s_axis_tdata[63:32] : s_axis_tdata[63:32];
      abs_im <= s_axis_tdata[95] ? 32'd0 - s_axis_tdata[95:64] : s_axis_tdata[95:64];
    end
    if (state == ST_PIVOT) begin
      pivot <= piv_sat[30:0];
      if (failed) begin
        res_pivot  <= diag;
        res_mr     <= last ? 32'd0 : off_re;
        res_mi     <= last ? 32'd0 : off_im;
        res_status <= STATUS_PASSED;
      end else if (piv_bad) begin
        res_pivot  <= piv_sat;
        res_mr     <= last ? 32'd0 : off_re;
        res_mi     <= last ? 32'd0 : off_im;
        res_status <= STATUS_FIRST_FAIL;
      end else begin
        res_pivot  <= piv_sat;
        res_mr     <= 32'd0;
        res_mi     <= 32'd0;
        res_status <= STATUS_FACTORED;
      end
    end
    if (state == ST_DIV && div_mag.done) begin
      res_mr <= sat_quot(off_re[31], div_re.ovf, div_re.quot);
      res_mi <= sat_quot(off_im[31], div_im.ovf, div_im.quot);
    end
    if (state == ST_DONE && out_free) begin
      m_axis_tdata <= {fail_row, res_mi, res_mr, res_pivot};
      m_axis_tuser <= res_status;
      m_axis_tlast <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      corr          <= '0;
      failed        <= 1'b0;
      row_cnt       <= '0;
      fail_row      <= '0;
    end else begin
      if (state == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (state == ST_PIVOT && !failed && piv_bad) begin
        failed   <= 1'b1;
        corr     <= '0;
        fail_row <= row_1based;
      end
      if (state == ST_DIV && div_mag.done) begin
        corr <= div_mag.ovf ? SAT_POS[30:0] : div_mag.quot;
      end
      if (state == ST_DONE && out_free) begin
        if (last) begin
          corr     <= '0;
          failed   <= 1'b0;
          row_cnt  <= '0;
          fail_row <= '0;
        end else if (row_cnt != {ROW_BITS{1'b1}}) begin
          row_cnt <= row_cnt + ROW_BITS'(1);
        end
      end
    end
  end

endmodule

// ===== tb/tb_tridiagonal_ldlh_factor.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tridiagonal_ldlh_factor: self-checking bench for the LDL^H row factorizer
// Sends a directed table of rows, then random matrices, while both stream
// sides idle at random. Each accepted row runs through a local recurrence
// model; results are compared field by field to it, typed rows to the table.
// ----------------------------------------------------------------------------
module tb_tridiagonal_ldlh_factor;
  import tdl_pkg::*;

  localparam int ROW_BITS    = 16;
  localparam int RANDOM_ROWS = 1850;
  localparam int NUM_DIR     = 21;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [31:0] diag;
    logic [31:0] off_re;
    logic [31:0] off_im;
    logic        is_last;
  } ldl_row_t;

  typedef struct packed {
    logic [31:0] pivot;
    logic [31:0] mult_re;
    logic [31:0] mult_im;
    logic [1:0]  status;
    logic [15:0] fail_row;
    logic        is_last;
  } ldl_result_t;

  typedef struct packed {
    logic [31:0] diag;
    logic [31:0] off_re;
    logic [31:0] off_im;
    logic        is_last;
    logic        typed;
    logic [31:0] pivot;
    logic [31:0] mult_re;
    logic [31:0] mult_im;
    logic [1:0]  status;
    logic [15:0] fail_row;
  } row_vec_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic [95:0]  s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tready = 1'b0;
  logic         s_axis_tready;
  logic         m_axis_tvalid;
  logic [111:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  // Model state of the recurrence.
  logic [31:0]  carry_corr = '0;
  logic         in_failure = 1'b0;
  longint       row_idx = 0;
  logic [15:0]  first_fail = '0;

  ldl_result_t  pending_rows [$];
  ldl_result_t  got_want;
  int           err_cnt = 0;
  int           rows_sent = 0;

  row_vec_t dir_tab [NUM_DIR] = '{
    '{32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000, 1'b0, 1'b1,
      32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000, STATUS_FIRST_FAIL, 16'd1},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1,
      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, STATUS_PASSED, 16'd1},
    '{32'h0005_0000, 32'h0003_0000, 32'h0003_0000, 1'b1, 1'b1,
      32'h0005_0000, 32'h0, 32'h0, STATUS_PASSED, 16'd1},
    '{32'h8000_0000, 32'h1234_5678, 32'h8765_4321, 1'b1, 1'b1,
      32'h8000_0000, 32'h0, 32'h0, STATUS_FIRST_FAIL, 16'd1},
    '{32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1,
      32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, STATUS_FACTORED, 16'd0},
    '{32'h8000_0000, 32'h0, 32'h0, 1'b0, 1'b1,
      32'h8000_0000, 32'h0, 32'h0, STATUS_FIRST_FAIL, 16'd2},
    '{32'h0001_0000, 32'h5555_AAAA, 32'hAAAA_5555, 1'b1, 1'b1,
      32'h0001_0000, 32'h0, 32'h0, STATUS_PASSED, 16'd2},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1,
      32'h7FFF_FFFF, 32'h0001_0000, 32'h0001_0000, STATUS_FACTORED, 16'd0},
    '{32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 1'b1,
      32'h0000_0000, 32'h0, 32'h0, STATUS_FIRST_FAIL, 16'd2},
    '{32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 1'b1,
      32'hFFFF_FFFF, 32'h0, 32'h0, STATUS_PASSED, 16'd2},
    '{32'h0004_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, 1'b0,
      32'h0, 32'h0, 32'h0, STATUS_FACTORED, 16'd0},
    '{32'h0004_0000, 32'h0000_8000, 32'hFFFF_8000, 1'b0, 1'b0,
      32'h0, 32'h0, 32'h0, STATUS_FACTORED, 16'd0},
    '{32'h0004_0000, 32'h0, 32'h0, 1'b1, 1'b0,
      32'h0, 32'h0, 32'h0, STATUS_FACTORED, 16'd0},
    '{32'h0002_0000, 32'hFFFD_0000, 32'h8000_0000, 1'b0, 1'b0,
      32'h0, 32'h0, 32'h0, STATUS_FACTORED, 16'd0},
    '{32'h0001_0000, 32'h0, 32'h0, 1'b1, 1'b1,
      32'h8001_0001, 32'h0, 32'h0, STATUS_FIRST_FAIL, 16'd2},
    '{32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 1'b1, 1'b1,
      32'h0003_0000, 32'h0, 32'h0, STATUS_FACTORED, 16'd0},
    '{32'h0003_0000, 32'hFFFF_0000, 32'h0001_0000, 1'b0, 1'b0,
      32'h0, 32'h0, 32'h0, STATUS_FACTORED, 16'd0},
    '{32'h0000_0001, 32'h0, 32'h0, 1'b0, 1'b0,
      32'h0, 32'h0, 32'h0, STATUS_FACTORED, 16'd0},
    '{32'h0000_0000, 32'h0, 32'h0, 1'b1, 1'b0,
      32'h0, 32'h0, 32'h0, STATUS_FACTORED, 16'd0},
    '{32'h0001_0000, 32'h0, 32'h0, 1'b0, 1'b0,
      32'h0, 32'h0, 32'h0, STATUS_FACTORED, 16'd0},
    '{32'h0000_0000, 32'h0, 32'h0, 1'b1, 1'b1,
      32'h0000_0000, 32'h0, 32'h0, STATUS_FIRST_FAIL, 16'd2}
  };

  tridiagonal_ldlh_factor #(
    .ROW_BITS(ROW_BITS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tlast (s_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #4 clk = ~clk;

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return SAT_POS;
    if (v < -64'sd2147483648) return SAT_NEG;
    return v[31:0];
  endfunction

  // Advances the recurrence by one row and returns the result it must give.
  function automatic ldl_result_t factor_row(input ldl_row_t r);
    ldl_result_t res;
    longint      d, er, ei, p;
    u64_t        mag, quo;
    res = '0;
    res.is_last = r.is_last;
    d  = longint'($signed(r.diag));
    er = longint'($signed(r.off_re));
    ei = longint'($signed(r.off_im));
    if (in_failure) begin
      res.pivot  = r.diag;
      res.status = STATUS_PASSED;
      if (!r.is_last) begin
        res.mult_re = r.off_re;
        res.mult_im = r.off_im;
      end
    end else begin
      p = longint'($signed(clamp32(d - longint'(carry_corr))));
      res.pivot = p[31:0];
      if (p <= 0) begin
        first_fail = (row_idx + 1 > 64'hFFFF) ? FAIL_ROW_MAX : 16'(row_idx + 1);
        in_failure = 1'b1;
        carry_corr = '0;
        res.status = STATUS_FIRST_FAIL;
        if (!r.is_last) begin
          res.mult_re = r.off_re;
          res.mult_im = r.off_im;
        end
      end else begin
        res.status = STATUS_FACTORED;
        if (!r.is_last) begin
          res.mult_re = clamp32((er * 65536) / p);
          res.mult_im = clamp32((ei * 65536) / p);
          mag = u64_t'(er * er) + u64_t'(ei * ei);
          quo = mag / u64_t'(p);
          carry_corr = (quo > 64'h7FFF_FFFF) ? SAT_POS : quo[31:0];
        end
      end
    end
    res.fail_row = first_fail;
    if (r.is_last) begin
      carry_corr = '0;
      in_failure = 1'b0;
      row_idx    = 0;
      first_fail = '0;
    end else if (row_idx < (longint'(1) << ROW_BITS) - 1) begin
      row_idx++;
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rand_signed(input int unsigned m);
    return $urandom_range(0, 2 * m) - m;
  endfunction

  task automatic send_row(input ldl_row_t r, input bit no_gap, input bit typed,
                          input ldl_result_t typed_want);
    int          g;
    ldl_result_t want;
    g = no_gap ? 0 : pick_gap();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r.off_im, r.off_re, r.diag};
    s_tlast  <= r.is_last;
    do @(posedge clk); while (!s_axis_tready);
    want = factor_row(r);
    pending_rows.push_back(typed ? typed_want : want);
    rows_sent++;
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_rows.size() != 0);
  endtask

  task automatic run_matrices();
    int          kind, len, fail_at;
    bit          burst;
    int unsigned base;
    ldl_row_t    r;
    while (rows_sent < RANDOM_ROWS) begin
      kind = $urandom_range(0, 9);
      len = ($urandom_range(0, 29) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 12);
      base = 1 << $urandom_range(4, 28);
      fail_at = (kind == 1) ? $urandom_range(0, len - 1) : -1;
      burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) == 0) wait_drain();
      for (int i = 0; i < len; i++) begin
        if (kind == 0) begin
          r = {$urandom, $urandom, $urandom, 1'b0};
          r.is_last = (i == len - 1) || ($urandom_range(0, 3) == 0);
        end else begin
          r.diag    = base + $urandom_range(0, base);
          r.off_re  = rand_signed(base >> 3);
          r.off_im  = rand_signed(base >> 3);
          r.is_last = (i == len - 1);
          if (i == fail_at) r.diag = -$urandom_range(0, base);
        end
        send_row(r, burst, 1'b0, '0);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_tready) begin
      if (pending_rows.size() == 0) begin
        $error("result with no request pending: tdata=%h", m_axis_tdata);
        err_cnt++;
      end else begin
        got_want = pending_rows.pop_front();
        check_field("pivot_out", got_want.pivot, m_axis_tdata[31:0]);
        check_field("mult_real", got_want.mult_re, m_axis_tdata[63:32]);
        check_field("mult_imag", got_want.mult_im, m_axis_tdata[95:64]);
        check_field("fail_row", 32'(got_want.fail_row), 32'(m_axis_tdata[111:96]));
        check_field("row_status", 32'(got_want.status), 32'(m_axis_tuser));
        check_field("last_out", 32'(got_want.is_last), 32'(m_axis_tlast));
      end
    end
  end

  initial begin
    int n;
    while (rst) @(posedge clk);
    forever begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(200, 600)) @(posedge clk);
      else repeat ($urandom_range(1, 24)) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    ldl_result_t tw;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_tab[i]) begin
      tw = {dir_tab[i].pivot, dir_tab[i].mult_re, dir_tab[i].mult_im,
            dir_tab[i].status, dir_tab[i].fail_row, dir_tab[i].is_last};
      send_row({dir_tab[i].diag, dir_tab[i].off_re, dir_tab[i].off_im, dir_tab[i].is_last},
               1'b0, dir_tab[i].typed, tw);
    end
    wait_drain();
    rows_sent = 0;
    run_matrices();
    wait_drain();
    repeat (48) @(posedge clk);
    if (err_cnt == 0) begin
      $display("** tridiagonal_ldlh_factor: PASSED **");
    end else begin
      $display("** tridiagonal_ldlh_factor: FAILED **");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("** tridiagonal_ldlh_factor: FAILED **");
    $finish;
  end

endmodule

// ===== tridiagonal_ldlh_factor.f =====
design/tdl_pkg.sv
design/tdl_div.sv
design/tdl_mag.sv
design/tridiagonal_ldlh_factor.sv
tb/tb_tridiagonal_ldlh_factor.sv
